FILE: sv/hlfd_pkg.sv
package hlfd_pkg;

  // Header bytes, tail byte and the smallest legal frame length.
  localparam logic [7:0]  HDR_FIRST       = 8'hFF;
  localparam logic [7:0]  HDR_SECOND      = 8'hAA;
  localparam logic [7:0]  TAIL_BYTE       = 8'h0A;
  localparam logic [11:0] MIN_FRAME_BYTES = 12'd9;

  // Offsets with a fixed meaning inside a frame.
  localparam logic [11:0] POS_FIRST_DATA = 12'd2;
  localparam logic [11:0] POS_SUM_START  = 12'd3;
  localparam logic [11:0] POS_LEN_HIGH   = 12'd5;
  localparam logic [11:0] POS_LEN_LOW    = 12'd6;

  // Hunt phase of the deframer.
  typedef enum logic [1:0] {
    PHASE_FIRST  = 2'd0,
    PHASE_SECOND = 2'd1,
    PHASE_FRAME  = 2'd2
  } phase_e;

  // End status carried on the last word of a frame.
  typedef enum logic [1:0] {
    STAT_BUSY     = 2'd0,
    STAT_GOOD     = 2'd1,
    STAT_CSUM_ERR = 2'd2,
    STAT_ABORT    = 2'd3
  } status_e;

  // One received word held in the input register.
  typedef struct packed {
    logic [7:0] rx_byte;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [7:0]  frame_byte;
    logic [11:0] byte_offset;
    logic        frame_last;
    status_e     frame_status;
  } result_t;

endpackage

FILE: sv/hlfd_in_stage.sv
module hlfd_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  logic [7:0]       s_data_i,
  input  logic             take_i,
  output logic             valid_o,
  output hlfd_pkg::in_word_t word_o
);

  logic               valid_q;
  logic               valid_d;
  hlfd_pkg::in_word_t word_q;
  logic               load;

  // The register can take a new word when it is empty or drained this cycle.
  assign s_ready_o = !valid_q || take_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q.rx_byte <= s_data_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

FILE: sv/hlfd_core.sv
module hlfd_core #(
  parameter int unsigned MAX_FRAME_BYTES = 4095
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               fire_i,
  input  hlfd_pkg::in_word_t word_i,
  output logic               emit_o,
  output hlfd_pkg::result_t  result_o
);

  localparam logic [11:0] MaxLen  = 12'(MAX_FRAME_BYTES);
  localparam logic [11:0] LastPos = 12'(MAX_FRAME_BYTES - 1);

  hlfd_pkg::phase_e phase_q, phase_d;
  logic [11:0]      pos_q, pos_d;
  logic [11:0]      len_q, len_d;
  logic [3:0]       chk_q, chk_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       prev_q, prev_d;
  logic             negate_q;

  logic [7:0]        b;
  logic [11:0]       len_full;
  logic [5:0]        nib_sum;
  logic [3:0]        chk_want;
  logic [7:0]        csum_want;
  logic [12:0]       pos_next;
  logic              last;
  hlfd_pkg::status_e status;

  assign b        = word_i.rx_byte;
  assign pos_next = {1'b0, pos_q} + 13'd1;

  // Length as seen at offset 6 and its expected check nibble.
  assign len_full = {len_q[11:8], b};
  assign nib_sum  = 6'(len_full[11:8]) + 6'(len_full[7:4]) + 6'(len_full[3:0]);
  assign chk_want = 4'(6'd0 - nib_sum);

  // Checksum the frame should carry just before the tail.
  assign csum_want = negate_q ? 8'(8'd0 - sum_q) : sum_q;

  // Frame end detection and state update for one word.
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    len_d   = len_q;
    chk_d   = chk_q;
    sum_d   = sum_q;
    prev_d  = prev_q;
    last    = 1'b0;
    status  = hlfd_pkg::STAT_BUSY;
    emit_o  = 1'b0;

    unique case (phase_q)
      hlfd_pkg::PHASE_SECOND: begin
        if (b == hlfd_pkg::HDR_SECOND) begin
          phase_d = hlfd_pkg::PHASE_FRAME;
          pos_d   = hlfd_pkg::POS_FIRST_DATA;
          sum_d   = 8'd0;
          prev_d  = 8'd0;
        end else if (b != hlfd_pkg::HDR_FIRST) begin
          phase_d = hlfd_pkg::PHASE_FIRST;
        end
      end
      hlfd_pkg::PHASE_FRAME: begin
        emit_o = 1'b1;
        if (pos_q == hlfd_pkg::POS_LEN_HIGH) begin
          chk_d = b[7:4];
          len_d = {b[3:0], 8'd0};
        end else if (pos_q == hlfd_pkg::POS_LEN_LOW) begin
          len_d = len_full;
          if (chk_want != chk_q || len_full < hlfd_pkg::MIN_FRAME_BYTES ||
              len_full > MaxLen) begin
            last   = 1'b1;
            status = hlfd_pkg::STAT_ABORT;
          end
        end else if (pos_q > hlfd_pkg::POS_LEN_LOW && pos_next >= {1'b0, len_q} &&
                     b == hlfd_pkg::TAIL_BYTE) begin
          last   = 1'b1;
          status = (csum_want == prev_q) ? hlfd_pkg::STAT_GOOD : hlfd_pkg::STAT_CSUM_ERR;
        end

        // Overrun: no tail by the last allowed offset.
        if (!last && pos_q >= LastPos) begin
          last   = 1'b1;
          status = hlfd_pkg::STAT_ABORT;
        end

        if (last) begin
          phase_d = hlfd_pkg::PHASE_FIRST;
          pos_d   = 12'd0;
          len_d   = 12'd0;
          chk_d   = 4'd0;
          sum_d   = 8'd0;
          prev_d  = 8'd0;
        end else begin
          if (pos_q >= hlfd_pkg::POS_SUM_START) begin
            sum_d = sum_q + prev_q;
          end
          prev_d = b;
          pos_d  = pos_next[11:0];
        end
      end
      default: begin
        // Hunting for the first header byte; the unused code hunts too.
        phase_d = (b == hlfd_pkg::HDR_FIRST) ? hlfd_pkg::PHASE_SECOND
                                             : hlfd_pkg::PHASE_FIRST;
      end
    endcase
  end

  assign result_o.frame_byte   = b;
  assign result_o.byte_offset  = pos_q;
  assign result_o.frame_last   = last;
  assign result_o.frame_status = status;

  // Deframer state advances once per consumed word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hlfd_pkg::PHASE_FIRST;
      pos_q   <= 12'd0;
      len_q   <= 12'd0;
      chk_q   <= 4'd0;
      sum_q   <= 8'd0;
      prev_q  <= 8'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      chk_q   <= chk_d;
      sum_q   <= sum_d;
      prev_q  <= prev_d;
    end
  end

  // Checksum polarity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      negate_q <= 1'b0;
    end else if (cfg_we_i) begin
      negate_q <= cfg_wdata_i;
    end
  end

endmodule

FILE: sv/hlfd_out_stage.sv
module hlfd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  hlfd_pkg::result_t result_i,
  output logic              can_take_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output hlfd_pkg::result_t result_o
);

  logic              valid_q;
  logic              valid_d;
  hlfd_pkg::result_t result_q;

  // The result register frees up in the same cycle its word is taken.
  assign can_take_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign m_valid_o = valid_q;
  assign result_o  = result_q;

endmodule

FILE: sv/header_length_frame_deframer_top.sv
// Header/length frame deframer.
// The slave stream takes one received byte per word in s_axis_tdata_i. The
// block hunts for the header FF AA, reads the length and its check nibble at
// offsets 5 and 6, and passes every frame byte from offset 2 on to the master
// stream with its offset. The word that ends or aborts a frame carries tlast
// and an end status in tuser: good end, checksum error, or length/overrun abort.
// Header bytes and bytes outside a frame produce no output word.
// cfg_we_i/cfg_wdata_i set the checksum polarity (1: negated sum); write it
// only while the block is idle.
// Throughput is one byte per cycle while the receiver keeps up. A byte passes
// an input register and then the per-byte decode into the result register,
// which drives the output word. The result register is the only output
// buffer: when the receiver stalls, the input register still takes one more
// byte, after which s_axis_tready_o drops until the result word is taken.
// Reset marks both registers empty and clears the hunt state and the checksum polarity.
module header_length_frame_deframer_top #(
  parameter int unsigned MAX_FRAME_BYTES = 4095
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] frame_byte, [19:8] byte_offset, [23:20] zero
  output logic        m_axis_tlast_o,   // frame_last
  output logic [1:0]  m_axis_tuser_o    // [1:0] frame_status
);

  hlfd_pkg::in_word_t in_word;
  hlfd_pkg::result_t  core_result;
  hlfd_pkg::result_t  out_result;
  logic               in_valid;
  logic               out_can_take;
  logic               fire;
  logic               emit;

  // A held word is consumed once the result register has room for it.
  assign fire = in_valid && out_can_take;

  hlfd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_data_i  (s_axis_tdata_i),
    .take_i    (fire),
    .valid_o   (in_valid),
    .word_o    (in_word)
  );

  hlfd_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .word_i      (in_word),
    .emit_o      (emit),
    .result_o    (core_result)
  );

  hlfd_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire && emit),
    .result_i   (core_result),
    .can_take_o (out_can_take),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .result_o   (out_result)
  );

  assign m_axis_tdata_o = {4'd0, out_result.byte_offset, out_result.frame_byte};
  assign m_axis_tlast_o = out_result.frame_last;
  assign m_axis_tuser_o = out_result.frame_status;

endmodule

FILE: sv/hlfd_checker.sv
module hlfd_checker #(
  parameter int unsigned MAX_FRAME_BYTES = 4095
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic [1:0]  m_axis_tuser_o
);

  localparam logic [11:0] LastPos = 12'(MAX_FRAME_BYTES - 1);

  // A stalled output word holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) &&
      $stable(m_axis_tuser_o))
    else $error("output word changed while stalled");

  // The end status is nonzero exactly on the last word of a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o != hlfd_pkg::STAT_BUSY)))
    else $error("frame status does not match frame end flag");

  // Emitted offsets lie between the first data byte and the overrun limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[19:8] >= hlfd_pkg::POS_FIRST_DATA &&
                        m_axis_tdata_o[19:8] <= LastPos && m_axis_tdata_o[23:20] == 4'd0)
    else $error("output offset out of range");

  // Before the length is complete a frame can only end by a length abort.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o && m_axis_tdata_o[19:8] <= hlfd_pkg::POS_LEN_LOW |->
      m_axis_tuser_o == hlfd_pkg::STAT_ABORT)
    else $error("early frame end without abort status");

endmodule

bind header_length_frame_deframer_top hlfd_checker #(
  .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
) u_hlfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_FRAME  = 4095;
  localparam int          SETTLE_PAD = 6;     // cycles after the last result before a write
  localparam int          LONG_HOLD  = 300;   // long receiver hold-off, in cycles
  localparam int          STALL_LIMIT = 2000; // cycles without any word moving

  // How a row of the directed table is checked.
  typedef enum logic [1:0] {
    ROW_SILENT  = 2'd0,
    ROW_PREDICT = 2'd1,
    ROW_TYPED   = 2'd2
  } row_kind_e;

  typedef struct packed {
    logic [7:0]        rx;
    row_kind_e         kind;
    logic [11:0]       off;
    logic              last;
    hlfd_pkg::status_e st;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic [1:0]  m_axis_tuser_o;

  // Copy of the deframer state and its checksum polarity.
  hlfd_pkg::phase_e hunt_phase;
  logic [11:0]      frame_pos;
  logic [11:0]      frame_len;
  logic [3:0]       len_check_nib;
  logic [7:0]       byte_sum;
  logic [7:0]       last_byte;
  logic             negate_sum;

  hlfd_pkg::result_t pending_frame_words[$];
  logic [7:0]        frame_bytes[$];

  int          results_predicted = 0;
  int          bytes_sent        = 0;
  int          words_checked     = 0;
  int          good_ends         = 0;
  int          csum_errors       = 0;
  int          aborts            = 0;
  int          mismatch_count    = 0;
  int          quiet_cycles      = 0;
  int          burst_left        = 0;
  int          holds_done        = 0;
  bit          hold_request      = 1'b0;

  // Directed bytes: hunting, a bad length check, a too short length and a
  // minimal good frame that carries the extreme byte values.
  stim_row_t directed_rows [0:24] = '{
    '{8'h00, ROW_SILENT,  12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'hFF, ROW_SILENT,  12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'hFF, ROW_SILENT,  12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'hAA, ROW_SILENT,  12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'h12, ROW_PREDICT, 12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'h34, ROW_PREDICT, 12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'h56, ROW_PREDICT, 12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'h00, ROW_PREDICT, 12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'h09, ROW_TYPED,   12'd6, 1'b1, hlfd_pkg::STAT_ABORT},
    '{8'hFF, ROW_SILENT,  12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'hAA, ROW_SILENT,  12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'h01, ROW_PREDICT, 12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'h02, ROW_PREDICT, 12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'h03, ROW_PREDICT, 12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'h80, ROW_PREDICT, 12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'h08, ROW_TYPED,   12'd6, 1'b1, hlfd_pkg::STAT_ABORT},
    '{8'hFF, ROW_SILENT,  12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'hAA, ROW_SILENT,  12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'h00, ROW_PREDICT, 12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'hFF, ROW_PREDICT, 12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'hAA, ROW_PREDICT, 12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'h70, ROW_PREDICT, 12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'h09, ROW_PREDICT, 12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'h22, ROW_PREDICT, 12'd0, 1'b0, hlfd_pkg::STAT_BUSY},
    '{8'h0A, ROW_TYPED,   12'd8, 1'b1, hlfd_pkg::STAT_GOOD}
  };

  header_length_frame_deframer_top #(
    .MAX_FRAME_BYTES(MAX_FRAME)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  // The check nibble that a length must carry: minus its nibble sum, mod 16.
  function automatic logic [3:0] length_check(input logic [11:0] len);
    logic [3:0] nib_sum;
    nib_sum = len[11:8] + len[7:4] + len[3:0];
    return -nib_sum;
  endfunction

  task automatic clear_hunt();
    hunt_phase    = hlfd_pkg::PHASE_FIRST;
    frame_pos     = '0;
    frame_len     = '0;
    len_check_nib = '0;
    byte_sum      = '0;
    last_byte     = '0;
  endtask

  // Advances the deframer copy by one byte and queues the word it produces.
  task automatic deframe_byte(input logic [7:0] b);
    logic [11:0]       p;
    logic              done;
    hlfd_pkg::status_e st;
    logic [7:0]        want;
    if (hunt_phase == hlfd_pkg::PHASE_SECOND) begin
      if (b == hlfd_pkg::HDR_SECOND) begin
        hunt_phase = hlfd_pkg::PHASE_FRAME;
        frame_pos  = hlfd_pkg::POS_FIRST_DATA;
        byte_sum   = '0;
        last_byte  = '0;
      end else if (b != hlfd_pkg::HDR_FIRST) begin
        hunt_phase = hlfd_pkg::PHASE_FIRST;
      end
      return;
    end
    if (hunt_phase != hlfd_pkg::PHASE_FRAME) begin
      if (b == hlfd_pkg::HDR_FIRST) hunt_phase = hlfd_pkg::PHASE_SECOND;
      return;
    end
    p    = frame_pos;
    done = 1'b0;
    st   = hlfd_pkg::STAT_BUSY;
    if (p == hlfd_pkg::POS_LEN_HIGH) begin
      len_check_nib = b[7:4];
      frame_len     = {b[3:0], 8'h00};
    end else if (p == hlfd_pkg::POS_LEN_LOW) begin
      frame_len = {frame_len[11:8], b};
      if (length_check(frame_len) != len_check_nib ||
          frame_len < hlfd_pkg::MIN_FRAME_BYTES ||
          int'(frame_len) > int'(MAX_FRAME)) begin
        done = 1'b1;
        st   = hlfd_pkg::STAT_ABORT;
      end
    end else if (p > hlfd_pkg::POS_LEN_LOW && int'(p) + 1 >= int'(frame_len) &&
                 b == hlfd_pkg::TAIL_BYTE) begin
      want = negate_sum ? -byte_sum : byte_sum;
      done = 1'b1;
      st   = (want == last_byte) ? hlfd_pkg::STAT_GOOD : hlfd_pkg::STAT_CSUM_ERR;
    end
    if (!done && int'(p) + 1 >= int'(MAX_FRAME)) begin
      done = 1'b1;
      st   = hlfd_pkg::STAT_ABORT;
    end
    pending_frame_words.push_back('{frame_byte: b, byte_offset: p, frame_last: done,
                                    frame_status: st});
    results_predicted++;
    if (done) begin
      clear_hunt();
    end else begin
      if (p >= hlfd_pkg::POS_SUM_START) byte_sum = byte_sum + last_byte;
      last_byte = b;
      frame_pos = p + 12'd1;
    end
  endtask

  task automatic report_mismatch(input string what, input hlfd_pkg::result_t exp_w,
                                 input hlfd_pkg::result_t got_w);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("Mismatch at %0t (%s): expected byte %h offset %0d last %b status %0d,",
               $realtime, what, exp_w.frame_byte, exp_w.byte_offset, exp_w.frame_last,
               exp_w.frame_status);
      $display("  got byte %h offset %0d last %b status %0d", got_w.frame_byte,
               got_w.byte_offset, got_w.frame_last, got_w.frame_status);
    end
  endtask

  // Offers one byte in the sender's burst pattern and steps the prediction
  // when it is taken. Table rows may drop the prediction or replace it with a typed word.
  task automatic put_byte(input logic [7:0] b, input row_kind_e kind,
                          input hlfd_pkg::result_t typed);
    int gap;
    int queued;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    bytes_sent++;
    burst_left--;
    queued = pending_frame_words.size();
    deframe_byte(b);
    if (kind != ROW_PREDICT) begin
      while (pending_frame_words.size() > queued) void'(pending_frame_words.pop_back());
      if (kind == ROW_TYPED) pending_frame_words.push_back(typed);
    end
  endtask

  // Stops offering and waits until the block has delivered everything.
  task automatic settle_idle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_frame_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_PAD) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_negate(input logic value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    negate_sum = value;
  endtask

  // Frame content leans toward header and tail values to stress the hunt.
  function automatic logic [7:0] pick_data();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return hlfd_pkg::HDR_FIRST;
    if (r < 16) return hlfd_pkg::HDR_SECOND;
    if (r < 22) return hlfd_pkg::TAIL_BYTE;
    if (r < 26) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Builds a well-formed frame whose tail sits extra bytes past length-1; corrupt spoils its checksum.
  task automatic build_good_frame(input int len, input int extra, input bit corrupt);
    int         tail;
    logic [7:0] sum;
    logic [7:0] d;
    tail = len - 1 + extra;
    frame_bytes.delete();
    frame_bytes.push_back(hlfd_pkg::HDR_FIRST);
    frame_bytes.push_back(hlfd_pkg::HDR_SECOND);
    repeat (3) frame_bytes.push_back(pick_data());
    frame_bytes.push_back({length_check(12'(len)), 4'(len >> 8)});
    frame_bytes.push_back(8'(len));
    for (int i = 7; i <= tail - 2; i++) begin
      d = pick_data();
      // Past length-1 a tail byte would end the frame early.
      if (i >= len - 1 && d == hlfd_pkg::TAIL_BYTE) d = 8'h0B + 8'($urandom_range(0, 8'hF4));
      frame_bytes.push_back(d);
    end
    sum = '0;
    for (int i = 2; i <= tail - 2; i++) sum = sum + frame_bytes[i];
    if (negate_sum) sum = -sum;
    if (corrupt) sum = sum + 8'($urandom_range(1, 255));
    frame_bytes.push_back(sum);
    frame_bytes.push_back(hlfd_pkg::TAIL_BYTE);
  endtask

  task automatic send_frame_bytes();
    foreach (frame_bytes[i]) put_byte(frame_bytes[i], ROW_PREDICT, hlfd_pkg::result_t'('0));
  endtask

  // Mostly good frames; the rest are bad sums, bad checks, short lengths, line noise
  // and frames cut off before their tail.
  task automatic send_random_frame();
    int          pick;
    int          len;
    int          extra;
    logic [11:0] bad_len;
    pick  = $urandom_range(0, 99);
    extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    len   = $urandom_range(0, 99);
    if (len < 88) len = $urandom_range(9, 24);
    else if (len < 98) len = $urandom_range(25, 160);
    else len = $urandom_range(161, 700);
    if (pick < 78) begin
      build_good_frame(len, extra, pick >= 70);
      if (pick % 10 == 0) frame_bytes.push_front(hlfd_pkg::HDR_FIRST);
    end else if (pick < 90) begin
      bad_len = (pick < 84) ? 12'($urandom_range(0, 4095)) : 12'($urandom_range(0, 8));
      frame_bytes.delete();
      frame_bytes.push_back(hlfd_pkg::HDR_FIRST);
      frame_bytes.push_back(hlfd_pkg::HDR_SECOND);
      repeat (3) frame_bytes.push_back(pick_data());
      if (pick < 84)
        frame_bytes.push_back({length_check(bad_len) ^ 4'($urandom_range(1, 15)),
                               bad_len[11:8]});
      else
        frame_bytes.push_back({length_check(bad_len), bad_len[11:8]});
      frame_bytes.push_back(bad_len[7:0]);
    end else if (pick < 95) begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 8)) frame_bytes.push_back(pick_data());
    end else begin
      build_good_frame(len, extra, 1'b0);
      while (frame_bytes.size() > 3 && $urandom_range(0, 3) != 0)
        void'(frame_bytes.pop_back());
    end
    send_frame_bytes();
  endtask

  // Sends random frames until about want input bytes have been taken; with_hold asks for one long hold-off.
  task automatic run_random(input int want, input bit with_hold);
    int start;
    bit held;
    start = bytes_sent;
    held  = 1'b0;
    while (bytes_sent - start < want) begin
      if (with_hold && !held && bytes_sent - start >= want / 3) begin
        hold_request = 1'b1;
        held         = 1'b1;
      end
      send_random_frame();
    end
  endtask

  // Receiver: follows a ready pattern that is redrawn at random; a request from the
  // stimulus forces one long hold-off.
  initial begin : receiver
    int mode;
    int cyc;
    int hold_left;
    mode = 0;
    cyc = 0;
    hold_left = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
        holds_done++;
      end
      if (cyc % 128 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= 1'($urandom_range(0, 1));
          2: m_axis_tready_i <= (cyc % 4 != 3);
          default: m_axis_tready_i <= ($urandom_range(0, 99) < 85);
        endcase
      end
      cyc++;
    end
  end

  // Compare every word taken from the master side with the oldest prediction.
  always @(posedge clk_i) begin : word_check
    hlfd_pkg::result_t got_w;
    hlfd_pkg::result_t exp_w;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_w.frame_byte   = m_axis_tdata_o[7:0];
      got_w.byte_offset  = m_axis_tdata_o[19:8];
      got_w.frame_last   = m_axis_tlast_o;
      got_w.frame_status = hlfd_pkg::status_e'(m_axis_tuser_o);
      words_checked++;
      if (m_axis_tlast_o) begin
        case (got_w.frame_status)
          hlfd_pkg::STAT_GOOD:     good_ends++;
          hlfd_pkg::STAT_CSUM_ERR: csum_errors++;
          hlfd_pkg::STAT_ABORT:    aborts++;
          default:                 ;
        endcase
      end
      if (m_axis_tdata_o[23:20] != 4'h0) report_mismatch("pad bits set", got_w, got_w);
      if (pending_frame_words.size() == 0) begin
        report_mismatch("no word expected", hlfd_pkg::result_t'('0), got_w);
      end else begin
        exp_w = pending_frame_words.pop_front();
        if (got_w !== exp_w) report_mismatch("field differs", exp_w, got_w);
      end
    end
  end

  // Watchdog on words moving on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles, %0d words still due.",
                 quiet_cycles, pending_frame_words.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Main sequence: directed table, then random phases under both polarities.
  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    negate_sum      = 1'b0;
    clear_hunt();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_negate(1'b0);
    foreach (directed_rows[i])
      put_byte(directed_rows[i].rx, directed_rows[i].kind,
               '{frame_byte: directed_rows[i].rx, byte_offset: directed_rows[i].off,
                 frame_last: directed_rows[i].last, frame_status: directed_rows[i].st});
    settle_idle();

    run_random(440, 1'b0);
    settle_idle();
    write_negate(1'b1);
    run_random(440, 1'b1);
    settle_idle();
    write_negate(1'b0);
    run_random(440, 1'b0);
    settle_idle();

    $display("Fed %0d bytes, checked %0d of %0d predicted words: %0d good, %0d bad sums.",
             bytes_sent, words_checked, results_predicted, good_ends, csum_errors);
    $display("Saw %0d aborts under both polarities, %0d long hold(s), %0d mismatches.",
             aborts, holds_done, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
